// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/rcfr_pkg.sv -----
// Package: word types, register codes and channel scaling for the frame receiver.
`timescale 1ns / 1ps
package rcfr_pkg;

  localparam int STORED_BYTES_DEF = 7;
  localparam int STORE_DEPTH      = 7;
  localparam int CFG_IDX_W        = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [7:0]  HEADER_RESET  = 8'h66;
  localparam logic [7:0]  TAIL_RESET    = 8'h99;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd30;
  localparam logic [10:0] CHANNEL_BASE  = 11'd1000;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        link_up;
    logic        wifi_in_control;
    logic        frame_decoded;
    logic [10:0] roll_out;
    logic [10:0] pitch_out;
    logic [10:0] throttle_out;
    logic [10:0] yaw_out;
    logic [7:0]  aux_switch;
    logic [7:0]  good_frame_count;
  } out_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
    logic [7:0] link_timeout;
  } cfg_t;

  // 1000 + floor(b * 1000 / 256): constant multiply, then a shift.
  function automatic logic [10:0] scale_channel(input logic [7:0] b);
    logic [17:0] prod;
    prod = 18'(b) * 18'd1000;
    return CHANNEL_BASE + 11'(prod >> 8);
  endfunction

endpackage

// ----- hw/rtl/rcfr_cfg_regs.sv -----
// Configuration registers of the frame receiver.
`timescale 1ns / 1ps
module rcfr_cfg_regs
  import rcfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output cfg_t                 cfg
);

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.header_byte  <= HEADER_RESET;
      regs.tail_byte    <= TAIL_RESET;
      regs.link_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER:  regs.header_byte  <= cfg_data;
        REG_TAIL:    regs.tail_byte    <= cfg_data;
        REG_TIMEOUT: regs.link_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rcfr_core.sv -----
// Deframer, miss counter and channel decode; updates state once per word.
`timescale 1ns / 1ps
module rcfr_core
  import rcfr_pkg::*;
#(
  parameter int STORED_BYTES = STORED_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic fire,
  input  in_t  item,
  output out_t result
);

  localparam logic [2:0] LAST_POS = 3'(STORED_BYTES - 1);

  logic        in_frame, in_frame_next;
  logic [2:0]  stored_count, stored_count_next;
  logic [7:0]  frame_store [STORE_DEPTH];
  logic        store_we;
  logic [7:0]  miss_counter, miss_counter_next;
  logic [7:0]  miss_inc;
  logic        connected, connected_next;
  logic        source_wifi, source_wifi_next;
  logic [10:0] roll_reg, roll_reg_next;
  logic [10:0] pitch_reg, pitch_reg_next;
  logic [10:0] throttle_reg, throttle_reg_next;
  logic [10:0] yaw_reg, yaw_reg_next;
  logic [7:0]  aux_reg, aux_reg_next;
  logic [7:0]  decoded_count, decoded_count_next;
  logic        decode;

  always_comb begin
    in_frame_next      = in_frame;
    stored_count_next  = stored_count;
    store_we           = 1'b0;
    miss_counter_next  = miss_counter;
    connected_next     = connected;
    source_wifi_next   = source_wifi;
    roll_reg_next      = roll_reg;
    pitch_reg_next     = pitch_reg;
    throttle_reg_next  = throttle_reg;
    yaw_reg_next       = yaw_reg;
    aux_reg_next       = aux_reg;
    decoded_count_next = decoded_count;
    decode             = 1'b0;
    miss_inc           = miss_counter + 8'd1;

    if (fire) begin
      if (item.command == CMD_BYTE) begin
        if (!in_frame) begin
          if (item.rx_byte == cfg.header_byte) begin
            in_frame_next     = 1'b1;
            stored_count_next = 3'd0;
          end
        end else begin
          store_we = 1'b1;
          if (stored_count == LAST_POS) begin
            in_frame_next     = 1'b0;
            stored_count_next = 3'd0;
            if (item.rx_byte == cfg.tail_byte) begin
              miss_counter_next = 8'd0;
            end
          end else begin
            stored_count_next = stored_count + 3'd1;
          end
        end
      end else begin
        miss_counter_next = miss_inc;
        if (miss_inc == 8'd1) begin
          decode             = 1'b1;
          roll_reg_next      = scale_channel(frame_store[0]);
          pitch_reg_next     = scale_channel(frame_store[1]);
          throttle_reg_next  = scale_channel(frame_store[2]);
          yaw_reg_next       = scale_channel(frame_store[3]);
          aux_reg_next       = frame_store[4];
          decoded_count_next = decoded_count + 8'd1;
          connected_next     = 1'b1;
          source_wifi_next   = 1'b1;
        end
        // Drop after any decode on the same tick.
        if (miss_inc >= cfg.link_timeout) begin
          miss_counter_next = 8'd1;
          connected_next    = 1'b0;
          source_wifi_next  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      stored_count  <= 3'd0;
      miss_counter  <= 8'd0;
      connected     <= 1'b0;
      source_wifi   <= 1'b0;
      roll_reg      <= CHANNEL_BASE;
      pitch_reg     <= CHANNEL_BASE;
      throttle_reg  <= CHANNEL_BASE;
      yaw_reg       <= CHANNEL_BASE;
      aux_reg       <= 8'd0;
      decoded_count <= 8'd0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_store[i] <= 8'd0;
      end
    end else begin
      in_frame      <= in_frame_next;
      stored_count  <= stored_count_next;
      miss_counter  <= miss_counter_next;
      connected     <= connected_next;
      source_wifi   <= source_wifi_next;
      roll_reg      <= roll_reg_next;
      pitch_reg     <= pitch_reg_next;
      throttle_reg  <= throttle_reg_next;
      yaw_reg       <= yaw_reg_next;
      aux_reg       <= aux_reg_next;
      decoded_count <= decoded_count_next;
      if (store_we) begin
        frame_store[stored_count] <= item.rx_byte;
      end
    end
  end

  always_comb begin
    result.link_up          = connected_next;
    result.wifi_in_control  = source_wifi_next;
    result.frame_decoded    = decode;
    result.roll_out         = roll_reg_next;
    result.pitch_out        = pitch_reg_next;
    result.throttle_out     = throttle_reg_next;
    result.yaw_out          = yaw_reg_next;
    result.aux_switch       = aux_reg_next;
    result.good_frame_count = decoded_count_next;
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_idle_count_zero, in_frame || stored_count == 3'd0, "count set while idle")
  `ASSERT_ALWAYS(a_link_source_match, connected == source_wifi, "link and source disagree")
  `ASSERT_NEXT(a_decode_counts, decode, decoded_count == $past(decoded_count) + 8'd1, "count missed")

endmodule

// ----- hw/rtl/rcfr_out_stage.sv -----
// Result register with stall hold for the frame receiver.
`timescale 1ns / 1ps
module rcfr_out_stage
  import rcfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  out_t result,
  output logic take,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_word
);

  // Free when empty or when the held word leaves this edge.
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (take && load) begin
      out_word <= result;
    end
  end

endmodule

// ----- hw/rtl/rc_frame_receiver_with_failsafe.sv -----
// Top level of the link-frame receiver with failsafe.
`timescale 1ns / 1ps
//
//  channel | handshake            | word / fields
//  --------+----------------------+------------------------------------------
//  in      | in_valid, in_stall   | in_word: command, rx_byte
//  out     | out_valid, out_stall | out_word: link flags, four channels, aux,
//          |                      |   good-frame count
//  cfg     | cfg_valid, cfg_ready | cfg_index (0 header, 1 tail, 2 timeout),
//          |                      |   cfg_data
//
// One word per cycle sustained while out_stall stays low; a taken word passes
// the input register, then decode logic into the result register.
// Reset (rst, synchronous) clears the frame store, counters, held channels
// (to 1000) and the registers to their defaults; no clearing pass follows.
// A stalled result holds the result register; the input register keeps
// accepting until it too is full, then in_stall rises.
// The config port never stalls; write it only while no words are in flight.
module rc_frame_receiver_with_failsafe
  import rcfr_pkg::*;
#(
  parameter int STORED_BYTES = STORED_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t cfg;
  in_t  held;
  logic held_valid;
  logic take;
  logic advance;
  logic in_load;
  out_t result;

  rcfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held word into the core when the result register is free.
  assign advance  = held_valid && take;
  assign in_stall = held_valid && !take;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; capture a fresh word on accept.
  always_ff @(posedge clk) begin
    if (in_load) begin
      held <= in_word;
    end
  end

  rcfr_core #(
    .STORED_BYTES (STORED_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (held),
    .result (result)
  );

  rcfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_held_kept, held_valid && !take, held_valid, "held word lost")
  `ASSERT_NEXT(a_advance_shows, advance, out_valid, "advanced word not shown")
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled word changed")

endmodule

// ----- sim/rc_frame_receiver_with_failsafe_test.sv -----
// Self-checking bench for the link-frame receiver: directed table, then randomized phases.
`timescale 1ns / 1ps

module rc_frame_receiver_with_failsafe_test;
  import rcfr_pkg::*;

  // Bytes kept per frame after the header, as the block is built by default.
  localparam int FRAME_LEN = STORED_BYTES_DEF;
  // Long receiver hold-off, in cycles, that lets the block fill and stall its input.
  localparam int HOLD_CYCLES = 160;
  // Cycles with no handshake at all before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Extra cycles to drain before config writes and at the end.
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_WORDS = 120;
  localparam int NUM_PHASES = 5;

  // Clock, reset and all block inputs start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  in_t in_word = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
  logic [7:0] cfg_data = 8'h00;

  logic in_stall;
  logic out_valid;
  out_t out_word;
  logic cfg_ready;

  rc_frame_receiver_with_failsafe dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the receiver: deframer, failsafe counter and held channels.
  // ---------------------------------------------------------------------------
  logic [7:0]  sh_header  = HEADER_RESET;
  logic [7:0]  sh_tail    = TAIL_RESET;
  logic [7:0]  sh_timeout = TIMEOUT_RESET;
  logic        sh_in_frame = 1'b0;
  int          sh_pos = 0;
  logic [7:0]  sh_store [FRAME_LEN] = '{default: 8'h00};
  logic [7:0]  sh_miss = 8'd0;
  logic        sh_link = 1'b0;
  logic        sh_wifi = 1'b0;
  logic [10:0] sh_roll = 11'd1000;
  logic [10:0] sh_pitch = 11'd1000;
  logic [10:0] sh_throttle = 11'd1000;
  logic [10:0] sh_yaw = 11'd1000;
  logic [7:0]  sh_aux = 8'd0;
  logic [7:0]  sh_decodes = 8'd0;

  // Run statistics for the closing summary.
  int words_sent = 0;
  int ticks_sent = 0;
  int good_frames = 0;
  int decodes_seen = 0;
  int link_drops = 0;
  int results_seen = 0;
  int errors = 0;

  // Result words still owed by the block, oldest first.
  out_t link_status_q [$];

  logic no_idle = 1'b0;
  logic long_hold = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  // Exact integer form of 1000 + byte * 3.90625.
  function automatic logic [10:0] byte_to_channel(input logic [7:0] b);
    return 11'(1000 + (int'(b) * 1000) / 256);
  endfunction

  // Advance the shadow state by one word and return the status it yields.
  function automatic out_t next_link_status(input in_t w);
    out_t status;
    logic decoded;
    decoded = 1'b0;
    if (w.command == CMD_BYTE) begin
      if (!sh_in_frame) begin
        // Outside a frame only the header byte matters.
        if (w.rx_byte == sh_header) begin
          sh_in_frame = 1'b1;
          sh_pos = 0;
        end
      end else begin
        // Any byte inside a frame is data, a repeated header included.
        sh_store[sh_pos] = w.rx_byte;
        sh_pos = sh_pos + 1;
        if (sh_pos >= FRAME_LEN) begin
          sh_in_frame = 1'b0;
          sh_pos = 0;
          if (w.rx_byte == sh_tail) begin
            sh_miss = 8'd0;
            good_frames++;
          end
        end
      end
    end else begin
      ticks_sent++;
      sh_miss = sh_miss + 8'd1;
      // First tick since a good frame: decode whatever the store holds now.
      if (sh_miss == 8'd1) begin
        sh_roll = byte_to_channel(sh_store[0]);
        sh_pitch = byte_to_channel(sh_store[1]);
        sh_throttle = byte_to_channel(sh_store[2]);
        sh_yaw = byte_to_channel(sh_store[3]);
        sh_aux = sh_store[4];
        sh_decodes = sh_decodes + 8'd1;
        sh_link = 1'b1;
        sh_wifi = 1'b1;
        decoded = 1'b1;
        decodes_seen++;
      end
      // Failsafe: the drop wins over a decode on the same tick.
      if (sh_miss >= sh_timeout) begin
        sh_miss = 8'd1;
        sh_link = 1'b0;
        sh_wifi = 1'b0;
        link_drops++;
      end
    end
    status = '{sh_link, sh_wifi, decoded, sh_roll, sh_pitch, sh_throttle, sh_yaw,
               sh_aux, sh_decodes};
    return status;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_status(input out_t got, input out_t want);
    check_field("link_up", got.link_up, want.link_up);
    check_field("wifi_in_control", got.wifi_in_control, want.wifi_in_control);
    check_field("frame_decoded", got.frame_decoded, want.frame_decoded);
    check_field("roll_out", got.roll_out, want.roll_out);
    check_field("pitch_out", got.pitch_out, want.pitch_out);
    check_field("throttle_out", got.throttle_out, want.throttle_out);
    check_field("yaw_out", got.yaw_out, want.yaw_out);
    check_field("aux_switch", got.aux_switch, want.aux_switch);
    check_field("good_frame_count", got.good_frame_count, want.good_frame_count);
  endtask

  // Receiver: take a result word, compare it, then draw how long to stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (link_status_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          check_status(out_word, link_status_q.pop_front());
        end
        stall_left = no_idle ? 0 : $urandom_range(9, 0);
      end
      // Hold the output side while the long hold-off runs, else count down.
      if (long_hold || stall_left > 0) begin
        out_stall <= 1'b1;
        if (stall_left > 0) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long hold-off: once the random part is well under way, stop draining results
  // while the sender keeps offering words, so both registers fill and in_stall rises.
  initial begin
    wait (words_sent >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Watchdog: count cycles in which no handshake completes on any channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one word after a random gap; keep in_valid high across back-to-back
  // words so it is never dropped and raised in one step. Record the expected
  // status (typed-in where given, else from the shadow model) once taken.
  task automatic offer_word(input in_t w, input bit typed, input out_t want);
    int gap;
    out_t predicted;
    gap = (no_idle || long_hold) ? 0 : $urandom_range(9, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_link_status(w);
    link_status_q.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_word('{CMD_BYTE, b}, 1'b0, '0);
  endtask

  // Ticks carry a random byte that the block must ignore.
  task automatic send_tick();
    offer_word('{CMD_TICK, 8'($urandom_range(255, 0))}, 1'b0, '0);
  endtask

  // Write a register once the block has drained every word in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    in_valid <= 1'b0;
    while (link_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HEADER:  sh_header = value;
      REG_TAIL:    sh_tail = value;
      REG_TIMEOUT: sh_timeout = value;
      default: ;
    endcase
  endtask

  // Frame: header, then FRAME_LEN bytes. A good frame ends on the tail byte;
  // a broken one stops early or ends on a random byte. Optionally slip a tick
  // in mid-frame so the decode reads a partly overwritten store.
  task automatic send_frame(input bit good, input bit tick_inside);
    int len;
    int tick_at;
    logic [7:0] b;
    len = good ? FRAME_LEN : $urandom_range(FRAME_LEN, 1);
    tick_at = $urandom_range(len - 1, 0);
    send_byte(sh_header);
    for (int i = 0; i < len; i++) begin
      if (tick_inside && i == tick_at) send_tick();
      b = 8'($urandom_range(255, 0));
      if ($urandom_range(5, 0) == 0) b = sh_header;
      if (i == FRAME_LEN - 1) begin
        if (good) begin
          b = sh_tail;
        end else if (b == sh_tail) begin
          b = sh_tail ^ 8'h01;
        end
      end
      send_byte(b);
    end
  endtask

  // Mostly well-formed traffic with random content; the rest is broken
  // frames, runs of ticks and stray bytes.
  task automatic run_random_phase(input int count);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        send_frame(1'b1, $urandom_range(6, 0) == 0);
        repeat ($urandom_range(3, 1)) send_tick();
      end else if (pick < 60) begin
        send_frame(1'b0, $urandom_range(1, 0) == 1);
      end else if (pick < 82) begin
        repeat ($urandom_range(4, 1)) send_tick();
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255, 0)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           value;
    in_t                  w;
    bit                   typed;
    out_t                 want;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic plan_word(input logic cmd, input logic [7:0] b);
    plan.push_back('{1'b0, REG_HEADER, 8'h00, '{cmd, b}, 1'b0, '0});
  endtask

  task automatic plan_checked(input logic cmd, input logic [7:0] b, input out_t want);
    plan.push_back('{1'b0, REG_HEADER, 8'h00, '{cmd, b}, 1'b1, want});
  endtask

  task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    plan.push_back('{1'b1, idx, value, '0, 1'b0, '0});
  endtask

  initial begin
    // First tick after reset decodes the all-zero store and brings the link up.
    plan_checked(CMD_TICK, 8'hFF, '{1'b1, 1'b1, 1'b1, 11'd1000, 11'd1000, 11'd1000, 11'd1000,
                                    8'h00, 8'd1});
    // Second tick: counter at two, nothing decoded, outputs held.
    plan_checked(CMD_TICK, 8'h00, '{1'b1, 1'b1, 1'b0, 11'd1000, 11'd1000, 11'd1000, 11'd1000,
                                    8'h00, 8'd1});
    // Good frame with channel extremes and a header byte used as data.
    plan_word(CMD_BYTE, HEADER_RESET);
    plan_word(CMD_BYTE, 8'hFF);
    plan_word(CMD_BYTE, 8'h00);
    plan_word(CMD_BYTE, 8'h80);
    plan_word(CMD_BYTE, HEADER_RESET);
    plan_word(CMD_BYTE, 8'h5A);
    plan_word(CMD_BYTE, 8'h12);
    plan_word(CMD_BYTE, TAIL_RESET);
    plan_checked(CMD_TICK, 8'h55, '{1'b1, 1'b1, 1'b1, 11'd1996, 11'd1000, 11'd1500, 11'd1398,
                                    8'h5A, 8'd2});
    // Bad tail: the frame ends but the miss counter is kept.
    plan_word(CMD_BYTE, HEADER_RESET);
    for (int i = 1; i <= 6; i++) plan_word(CMD_BYTE, 8'(i));
    plan_word(CMD_BYTE, TAIL_RESET - 8'd1);
    plan_word(CMD_TICK, 8'hAA);
    // Timeout lowered to its floor, at the running count: next tick drops the link.
    plan_reg(REG_TIMEOUT, 8'd2);
    plan_checked(CMD_TICK, 8'h01, '{1'b0, 1'b0, 1'b0, 11'd1996, 11'd1000, 11'd1500, 11'd1398,
                                    8'h5A, 8'd2});
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        offer_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting: defaults, both sets
    // of extremes, then random values. One phase runs with no idling at all.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_HEADER, HEADER_RESET);
          write_reg(REG_TAIL, TAIL_RESET);
          write_reg(REG_TIMEOUT, TIMEOUT_RESET);
        end
        1: begin
          write_reg(REG_HEADER, 8'h00);
          write_reg(REG_TAIL, 8'hFF);
          write_reg(REG_TIMEOUT, 8'd255);
        end
        2: begin
          write_reg(REG_HEADER, 8'hFF);
          write_reg(REG_TAIL, 8'h00);
          write_reg(REG_TIMEOUT, 8'd2);
        end
        3: begin
          write_reg(REG_HEADER, 8'($urandom_range(255, 0)));
          write_reg(REG_TAIL, 8'($urandom_range(255, 0)));
          write_reg(REG_TIMEOUT, 8'($urandom_range(12, 2)));
        end
        default: begin
          write_reg(REG_HEADER, 8'($urandom_range(255, 0)));
          write_reg(REG_TAIL, 8'($urandom_range(255, 0)));
          write_reg(REG_TIMEOUT, 8'($urandom_range(255, 2)));
        end
      endcase
      no_idle <= (ph == 3);
      run_random_phase(PHASE_WORDS);
    end

    // Drain: wait for every owed result, then watch a few more cycles for strays.
    in_valid <= 1'b0;
    while (link_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d words sent (%0d ticks), %0d results checked, %0d mismatches",
             words_sent, ticks_sent, results_seen, errors);
    $display("tb: %0d good frames, %0d decodes, %0d link drops over %0d register settings",
             good_frames, decodes_seen, link_drops, NUM_PHASES + 1);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
